>>> hdl/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CpW       = 31;
  localparam int unsigned LenW      = 3;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned DataW     = CpW + LenW;
  localparam int unsigned OutTdataW = ((DataW + 7) / 8) * 8;

  // Lead and continuation byte patterns
  localparam logic [ByteW-1:0] ContMask   = 8'b1100_0000;
  localparam logic [ByteW-1:0] ContTag    = 8'b1000_0000;
  localparam logic [ByteW-1:0] Lead2Min   = 8'b1100_0000;
  localparam logic [ByteW-1:0] Lead3Min   = 8'b1110_0000;
  localparam logic [ByteW-1:0] Lead4Min   = 8'b1111_0000;
  localparam logic [ByteW-1:0] Lead5Min   = 8'b1111_1000;
  localparam logic [ByteW-1:0] Lead6Min   = 8'b1111_1100;
  localparam logic [ByteW-1:0] LeadMax    = 8'b1111_1101;

  typedef enum logic [StatusW-1:0] {
    ST_CHAR       = 2'd0,
    ST_INVALID    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_e;

  // Packed with code_point in the lowest bits
  typedef struct packed {
    logic [LenW-1:0] seq_bytes;
    status_e         status;
    logic [CpW-1:0]  code_point;
  } result_t;

endpackage

>>> hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder for the original encoding: sequences of 1 to 6 bytes,
// code points up to 0x7FFFFFFF, no overlong or surrogate checks. One byte
// enters per item on the slave side; tlast marks the last byte of a buffer.
// A result item (code point and sequence length on tdata, status on tuser)
// leaves on the master side when a character completes, when a sequence turns
// out invalid (stray continuation byte, 0xFE or 0xFF as lead, or a bad
// continuation byte, the latter reported when the expected length is
// reached), or when tlast cuts a sequence short (status incomplete, which wins
// over a bad continuation). Bytes in the middle of a sequence produce no
// result. Throughput is one byte per clock while the result side keeps up: an
// input register feeds a single decode step that updates the sequence state and
// loads the result register, so an accepted byte passes through the input
// register and then the result register. The byte that closes a sequence stalls
// only while the result register is full and not being taken.
module utf8_stream_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [u8dec_pkg::ByteW-1:0]      s_axis_tdata_i,   // [7:0] byte_value
  input  logic                             s_axis_tlast_i,   // last_byte
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [30:0] code_point, [33:31] seq_bytes, [39:34] zero
  output logic [u8dec_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  output logic [u8dec_pkg::StatusW-1:0]    m_axis_tuser_o    // [1:0] status
);
  import u8dec_pkg::*;

  // Input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  // Sequence state
  logic [CpW-1:0]   acc_q, acc_d;
  logic [LenW-1:0]  exp_q, exp_d;
  logic [LenW-1:0]  seen_q, seen_d;
  logic             bad_q, bad_d;

  // Result register
  logic             out_valid_q;
  result_t          res_q;

  // Decode step
  logic             emit;
  result_t          res_d;
  logic [LenW-1:0]  lead_len;
  logic [CpW-1:0]   lead_bits;
  logic [LenW-1:0]  seen_inc;
  logic             cont_ok;
  logic             bad_n;
  logic [CpW-1:0]   acc_n;
  logic             advance;

  // Work out sequence length and payload bits of a lead byte.
  always_comb begin
    priority if (in_byte_q >= Lead6Min) begin
      lead_len  = LenW'(6);
      lead_bits = CpW'(in_byte_q[0]);
    end else if (in_byte_q >= Lead5Min) begin
      lead_len  = LenW'(5);
      lead_bits = CpW'(in_byte_q[1:0]);
    end else if (in_byte_q >= Lead4Min) begin
      lead_len  = LenW'(4);
      lead_bits = CpW'(in_byte_q[2:0]);
    end else if (in_byte_q >= Lead3Min) begin
      lead_len  = LenW'(3);
      lead_bits = CpW'(in_byte_q[3:0]);
    end else begin
      lead_len  = LenW'(2);
      lead_bits = CpW'(in_byte_q[4:0]);
    end
  end

  assign seen_inc = seen_q + LenW'(1);
  assign cont_ok  = (in_byte_q & ContMask) == ContTag;
  assign bad_n    = bad_q | ~cont_ok;
  // Shift six payload bits in; the top bits fall off the 31-bit range.
  assign acc_n    = cont_ok ? {acc_q[CpW-7:0], in_byte_q[5:0]} : acc_q;

  always_comb begin
    acc_d  = acc_q;
    exp_d  = exp_q;
    seen_d = seen_q;
    bad_d  = bad_q;
    emit   = 1'b0;
    res_d  = '{seq_bytes: LenW'(1), status: ST_CHAR, code_point: '0};

    if (exp_q == '0) begin
      // Lead-byte state
      if (!in_byte_q[7]) begin
        emit             = 1'b1;
        res_d.code_point = CpW'(in_byte_q);
      end else if (in_byte_q < Lead2Min || in_byte_q > LeadMax) begin
        emit         = 1'b1;
        res_d.status = ST_INVALID;
      end else if (in_last_q) begin
        emit         = 1'b1;
        res_d.status = ST_INCOMPLETE;
      end else begin
        acc_d  = lead_bits;
        exp_d  = lead_len;
        seen_d = LenW'(1);
        bad_d  = 1'b0;
      end
    end else begin
      if (seen_inc >= exp_q) begin
        emit            = 1'b1;
        res_d.seq_bytes = exp_q;
        if (bad_n) begin
          res_d.status = ST_INVALID;
        end else begin
          res_d.code_point = acc_n;
        end
      end else if (in_last_q) begin
        emit            = 1'b1;
        res_d.seq_bytes = seen_inc;
        res_d.status    = ST_INCOMPLETE;
      end else begin
        acc_d  = acc_n;
        seen_d = seen_inc;
        bad_d  = bad_n;
      end
    end

    // Return to lead-byte state after any result.
    if (emit) begin
      acc_d  = '0;
      exp_d  = '0;
      seen_d = '0;
      bad_d  = 1'b0;
    end
  end

  // Advance the held byte unless it produces a result with nowhere to go.
  assign advance         = in_valid_q && (!emit || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      exp_q  <= '0;
      seen_q <= '0;
      bad_q  <= 1'b0;
    end else if (advance) begin
      acc_q  <= acc_d;
      exp_q  <= exp_d;
      seen_q <= seen_d;
      bad_q  <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - DataW){1'b0}}, res_q.seq_bytes, res_q.code_point};
  assign m_axis_tuser_o  = res_q.status;

  // An open sequence always has at least two bytes and is not yet complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != '0) |-> (exp_q >= LenW'(2) && seen_q != '0 && seen_q < exp_q))
    else $error("open sequence state out of range");

  // A loaded result leaves the decoder in lead-byte state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (exp_q == '0 && seen_q == '0 && !bad_q))
    else $error("state not cleared after result");

  // Only completed characters carry a code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status != ST_CHAR) |-> (res_q.code_point == '0))
    else $error("code point set on error result");

  // Sequence length of every result is between one and six.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.seq_bytes >= LenW'(1) && res_q.seq_bytes <= LenW'(6)))
    else $error("result sequence length out of range");

  // A full, stalled result register never gets overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !(advance && emit))
    else $error("result overwritten while stalled");

endmodule

>>> sim/utf8_stream_decoder_test.sv
`timescale 1ns / 100ps

package utf8_stream_decoder_test_pkg;
  import u8dec_pkg::*;

  // Decodes every accepted byte into the results the decoder should give, and
  // matches them in order against what comes out.
  class utf8_result_board;
    result_t         expected_q[$];
    logic [CpW-1:0]  cp_acc;
    logic [LenW-1:0] want_len;
    logic [LenW-1:0] seen_len;
    logic            bad_cont;
    int unsigned     errors;

    function new();
      cp_acc   = '0;
      want_len = '0;
      seen_len = '0;
      bad_cont = 1'b0;
      errors   = 0;
    endfunction

    // Queue one result and go back to lead-byte state
    function void close_seq(logic [CpW-1:0] cp, status_e st, logic [LenW-1:0] n);
      result_t r;
      r.code_point = cp;
      r.status     = st;
      r.seq_bytes  = n;
      expected_q.push_back(r);
      cp_acc   = '0;
      want_len = '0;
      seen_len = '0;
      bad_cont = 1'b0;
    endfunction

    function void note_byte(logic [ByteW-1:0] b, logic last);
      logic [LenW-1:0] width;
      logic [CpW-1:0]  bits;
      if (want_len == '0) begin
        if (b[7] == 1'b0) begin
          close_seq(CpW'(b), ST_CHAR, 3'd1);
        end else if (b < Lead2Min || b > LeadMax) begin
          // stray continuation byte, 0xFE or 0xFF
          close_seq('0, ST_INVALID, 3'd1);
        end else begin
          if (b >= Lead6Min) begin
            width = 3'd6;
            bits  = CpW'(b[0]);
          end else if (b >= Lead5Min) begin
            width = 3'd5;
            bits  = CpW'(b[1:0]);
          end else if (b >= Lead4Min) begin
            width = 3'd4;
            bits  = CpW'(b[2:0]);
          end else if (b >= Lead3Min) begin
            width = 3'd3;
            bits  = CpW'(b[3:0]);
          end else begin
            width = 3'd2;
            bits  = CpW'(b[4:0]);
          end
          if (last) begin
            close_seq('0, ST_INCOMPLETE, 3'd1);
          end else begin
            cp_acc   = bits;
            want_len = width;
            seen_len = 3'd1;
            bad_cont = 1'b0;
          end
        end
      end else begin
        seen_len = seen_len + 3'd1;
        if ((b & ContMask) != ContTag) begin
          bad_cont = 1'b1;
        end else begin
          cp_acc = {cp_acc[CpW-7:0], b[5:0]};
        end
        if (seen_len >= want_len) begin
          if (bad_cont) begin
            close_seq('0, ST_INVALID, want_len);
          end else begin
            close_seq(cp_acc, ST_CHAR, want_len);
          end
        end else if (last) begin
          // cut short wins over a bad continuation
          close_seq('0, ST_INCOMPLETE, seen_len);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endtask

    task check_result(logic [OutTdataW-1:0] tdata, logic [StatusW-1:0] tuser);
      result_t got;
      result_t want;
      got.code_point = tdata[CpW-1:0];
      got.seq_bytes  = tdata[DataW-1:CpW];
      got.status     = status_e'(tuser);
      if (expected_q.size() == 0) begin
        report($sformatf("result %h/%h with nothing expected", tdata, tuser));
        return;
      end
      want = expected_q.pop_front();
      if (got.code_point != want.code_point) begin
        report($sformatf("code_point %h, want %h", got.code_point, want.code_point));
      end
      if (got.status != want.status) begin
        report($sformatf("status %0d, want %0d", got.status, want.status));
      end
      if (got.seq_bytes != want.seq_bytes) begin
        report($sformatf("seq_bytes %0d, want %0d", got.seq_bytes, want.seq_bytes));
      end
      if (tdata[OutTdataW-1:DataW] != '0) begin
        report($sformatf("pad bits not zero in %h", tdata));
      end
    endtask

    task check_drained();
      if (expected_q.size() != 0) begin
        report($sformatf("%0d results never arrived", expected_q.size()));
      end
    endtask
  endclass

endpackage

module utf8_stream_decoder_test;
  import u8dec_pkg::*;
  import utf8_stream_decoder_test_pkg::*;

  localparam int     ClkHalf     = 5;
  localparam int     TargetItems = 1750;
  localparam int     HoldCycles  = 400;
  localparam int     DrainCycles = 16;
  localparam longint CycleLimit  = 1_000_000;

  logic                 clk     = 1'b0;
  logic                 rst_n   = 1'b0;
  logic                 s_valid = 1'b0;
  logic [ByteW-1:0]     s_data  = '0;
  logic                 s_last  = 1'b0;
  logic                 s_ready;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [OutTdataW-1:0] m_data;
  logic [StatusW-1:0]   m_user;

  bit          tx_steady  = 1'b0;
  bit          rx_steady  = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned items_sent = 0;
  longint      cycles     = 0;

  utf8_result_board board = new();

  utf8_stream_decoder u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #ClkHalf clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sample both handshakes on the edge where they complete
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_valid && m_ready) begin
        board.check_result(m_data, m_user);
      end
      if (s_valid && s_ready) begin
        board.note_byte(s_data, s_last);
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] lead_byte(int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      4:       return {5'b11110, r[2:0]};
      5:       return {6'b111110, r[1:0]};
      default: return {7'b1111110, r[0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // Any byte whose top bits are not 10
  function automatic logic [7:0] foreign_byte();
    logic [7:0] r;
    r = 8'($urandom);
    if (r[7:6] == 2'b10) r[6] = 1'b1;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    items_sent++;
  endtask

  // Send the first count bytes; tlast goes on the byte at index last_at
  task automatic send_run(input logic [7:0] bytes [6], input int count, input int last_at);
    for (int k = 0; k < count; k++) begin
      send_byte(bytes[k], k == last_at);
    end
  endtask

  task automatic random_traffic();
    logic [7:0] seq [6];
    int len;
    int pick;
    int cut;
    int n;
    while (items_sent < TargetItems) begin
      if ($urandom_range(0, 149) == 0) begin
        tx_steady = ($urandom_range(0, 2) == 0);
        rx_steady = ($urandom_range(0, 2) == 0);
      end
      len    = $urandom_range(1, 6);
      seq[0] = lead_byte(len);
      for (int k = 1; k < 6; k++) seq[k] = cont_byte();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_run(seq, len, ($urandom_range(0, 7) == 0) ? len - 1 : -1);
      end else if (pick < 80 && len > 1) begin
        seq[$urandom_range(1, len - 1)] = foreign_byte();
        send_run(seq, len, ($urandom_range(0, 7) == 0) ? len - 1 : -1);
      end else if (pick < 90 && len > 1) begin
        cut = $urandom_range(1, len - 1);
        send_run(seq, cut, cut - 1);
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) seq[k] = 8'($urandom);
        send_run(seq, n, ($urandom_range(0, 5) == 0) ? n - 1 : -1);
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = rx_steady ? 0 : idle_len();
        if (stall > 0) begin
          m_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ASCII extremes (0x7F with tlast), stray continuation bytes, 0xFE, 0xFF
    send_run('{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF}, 6, 1);
    // shortest and longest multi-byte sequences, smallest and largest code points
    send_run('{0: 8'hC0, 1: 8'h80, default: 8'h00}, 2, -1);
    send_run('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF}, 6, -1);
    // bad continuation, reported at the full length
    send_run('{0: 8'hE0, 1: 8'h41, 2: 8'h80, default: 8'h00}, 3, -1);
    // cut short, lone lead with tlast, cut short after a bad continuation
    send_run('{0: 8'hE0, 1: 8'h80, default: 8'h00}, 2, 1);
    send_run('{0: 8'hC2, default: 8'h00}, 1, 0);
    send_run('{0: 8'hF0, 1: 8'h41, default: 8'h00}, 2, 1);

    // Hold the result side off and keep feeding bytes so the input stalls
    tx_steady = 1'b1;
    hold_req  = 1'b1;
    for (int k = 0; k < 48; k++) send_byte(lead_byte(1), 1'b0);
    tx_steady = 1'b0;

    random_traffic();
    s_valid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    board.check_drained();
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
